// ===== src/ufbd_pkg.sv =====
// Shared constants, payload types and the sixteenths rounding function for
// the UART fractional baud divisor. No dependencies.
package ufbd_pkg;

  localparam longint unsigned CLK_HZ     = 64'd32000000;
  localparam int              SCALE      = 100;
  localparam int              OVERSAMPLE = 16;
  localparam int              LAST_STEP  = 15;

  localparam int RATE_W  = 24;
  localparam int WHOLE_W = 16;
  localparam int FRAC_W  = 4;

  // Quotient of the scaled clock by the oversampled rate equals this
  // constant divided by the rate.
  localparam longint unsigned DIVIDEND_VAL = CLK_HZ * SCALE / OVERSAMPLE;
  localparam int QUOT_W  = $clog2(DIVIDEND_VAL + 1);
  localparam logic [QUOT_W-1:0] DIVIDEND = QUOT_W'(DIVIDEND_VAL);
  localparam int QIDX_W  = $clog2(QUOT_W);

  // Quotient split into whole and hundredths by a reciprocal multiply.
  localparam int QWH_W       = $clog2(DIVIDEND_VAL / SCALE + 1);
  localparam int REM_W       = $clog2(SCALE);
  localparam int REM_EST_W   = $clog2(2 * SCALE);
  localparam int RECIP_SHIFT = 35;
  localparam longint unsigned RECIP_VAL = (64'd1 << RECIP_SHIFT) / SCALE;
  localparam int RECIP_W     = $clog2(RECIP_VAL + 1);
  localparam int PROD_W      = QUOT_W + RECIP_W;

  localparam logic [WHOLE_W-1:0] WHOLE_MAX = '1;
  localparam logic [FRAC_W-1:0]  FRAC_MAX  = FRAC_W'(LAST_STEP);

  localparam int DIV_BITS_DEF = 4;

  localparam logic [REM_W-1:0] SIXTEENTHS [0:LAST_STEP+1] = '{
    7'd0, 7'd6, 7'd13, 7'd19, 7'd25, 7'd31, 7'd38, 7'd44, 7'd50,
    7'd56, 7'd62, 7'd69, 7'd75, 7'd81, 7'd88, 7'd94, 7'd100
  };

  typedef struct packed {
    logic [QUOT_W-1:0] quot;
    logic              err;
  } div_res_t;

  typedef struct packed {
    logic [QWH_W-1:0] whole;
    logic [REM_W-1:0] rem;
    logic             err;
  } split_res_t;

  typedef struct packed {
    logic [WHOLE_W-1:0] whole;
    logic [FRAC_W-1:0]  frac;
    logic               err;
  } ufbd_res_t;

  // Rounds hundredths to the nearest sixteenth, ties low. A result of 16
  // means a carry into the whole part.
  function automatic logic [FRAC_W:0] round_frac(input logic [REM_W-1:0] rem);
    logic [FRAC_W:0] res;
    res = '0;
    for (int k = 0; k <= LAST_STEP; k++) begin
      if (rem >= SIXTEENTHS[k] && rem < SIXTEENTHS[k+1]) begin
        if ((rem - SIXTEENTHS[k]) <= (SIXTEENTHS[k+1] - rem)) begin
          res = (FRAC_W+1)'(k);
        end else begin
          res = (FRAC_W+1)'(k + 1);
        end
      end
    end
    return res;
  endfunction

endpackage

// ===== src/ufbd_if.sv =====
// Valid/ready channel interfaces for the rate input and the divisor result.
// Depends on ufbd_pkg.
interface ufbd_in_if import ufbd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] bit_rate;

  modport source(output valid, output bit_rate, input ready);
  modport sink(input valid, input bit_rate, output ready);
endinterface

interface ufbd_out_if import ufbd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WHOLE_W-1:0] divisor_whole;
  logic [FRAC_W-1:0]  divisor_fraction;
  logic               rate_error;

  modport source(output valid, output divisor_whole, output divisor_fraction,
                 output rate_error, input ready);
  modport sink(input valid, input divisor_whole, input divisor_fraction,
               input rate_error, output ready);
endinterface

// ===== src/ufbd_divider.sv =====
// Pipelined restoring divider: the constant scaled clock divided by the rate,
// a fixed number of quotient bits per stage. Depends on ufbd_pkg.
module ufbd_divider import ufbd_pkg::*; #(
  parameter int BITS_PER_STAGE = DIV_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [RATE_W-1:0] in_rate,
  output logic              out_valid,
  input  logic              out_ready,
  output div_res_t          out_res
);

  localparam int STAGES = (QUOT_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

  logic              v_r    [STAGES];
  logic [RATE_W-1:0] prem_r [STAGES];
  logic [QUOT_W-1:0] quot_r [STAGES];
  logic [RATE_W-1:0] den_r  [STAGES];
  logic              zero_r [STAGES];
  logic              stg_rdy[STAGES];

  genvar s;
  generate
    for (s = 0; s < STAGES; s++) begin : g_stage
      logic              src_valid;
      logic [RATE_W-1:0] src_prem;
      logic [QUOT_W-1:0] src_quot;
      logic [RATE_W-1:0] src_den;
      logic              src_zero;
      logic [RATE_W-1:0] prem_nxt;
      logic [QUOT_W-1:0] quot_nxt;
      logic              nxt_rdy;

      if (s == 0) begin : g_first
        assign src_valid = in_valid;
        assign src_prem  = '0;
        assign src_quot  = '0;
        assign src_den   = in_rate;
        assign src_zero  = (in_rate == '0);
      end else begin : g_rest
        assign src_valid = v_r[s-1];
        assign src_prem  = prem_r[s-1];
        assign src_quot  = quot_r[s-1];
        assign src_den   = den_r[s-1];
        assign src_zero  = zero_r[s-1];
      end

      if (s == STAGES - 1) begin : g_last_rdy
        assign nxt_rdy = out_ready;
      end else begin : g_mid_rdy
        assign nxt_rdy = stg_rdy[s+1];
      end

      assign stg_rdy[s] = !v_r[s] || nxt_rdy;

      // Each step brings down one dividend bit and subtracts the rate when
      // it fits; for a nonzero rate the partial remainder stays below the rate.
      always_comb begin
        logic [RATE_W:0] trial;
        int              idx;
        prem_nxt = src_prem;
        quot_nxt = src_quot;
        for (int b = 0; b < BITS_PER_STAGE; b++) begin
          idx = QUOT_W - 1 - s * BITS_PER_STAGE - b;
          if (idx >= 0) begin
            trial = {prem_nxt, DIVIDEND[idx[QIDX_W-1:0]]};
            if (trial >= {1'b0, src_den}) begin
              trial = trial - {1'b0, src_den};
              quot_nxt[idx[QIDX_W-1:0]] = 1'b1;
            end
            prem_nxt = trial[RATE_W-1:0];
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[s] <= 1'b0;
        end else if (stg_rdy[s]) begin
          v_r[s] <= src_valid;
        end
      end

      always_ff @(posedge clk) begin
        if (src_valid && stg_rdy[s]) begin
          prem_r[s] <= prem_nxt;
          quot_r[s] <= quot_nxt;
          den_r[s]  <= src_den;
          zero_r[s] <= src_zero;
        end
      end
    end
  endgenerate

  assign in_ready      = stg_rdy[0];
  assign out_valid     = v_r[STAGES-1];
  assign out_res.quot  = quot_r[STAGES-1];
  assign out_res.err   = zero_r[STAGES-1];

endmodule

// ===== src/ufbd_split.sv =====
// Splits the quotient into whole part and hundredths: a reciprocal multiply
// stage, then a multiply-back and single correction stage. Depends on ufbd_pkg.
module ufbd_split import ufbd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  div_res_t   in_res,
  output logic       out_valid,
  input  logic       out_ready,
  output split_res_t out_res
);

  localparam logic [PROD_W-1:0] RECIP = PROD_W'(RECIP_VAL);

  logic              a_v_r;
  logic [QUOT_W-1:0] a_quot_r;
  logic [QWH_W-1:0]  a_west_r;
  logic              a_err_r;
  logic              b_v_r;
  split_res_t        b_res_r;

  logic              a_rdy;
  logic              b_rdy;
  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] back;
  logic [QUOT_W-1:0] rem_full;
  logic [REM_EST_W-1:0] rem_est;
  split_res_t        b_res_nxt;

  assign b_rdy = !b_v_r || out_ready;
  assign a_rdy = !a_v_r || b_rdy;

  // The reciprocal is rounded down, so the estimate is low by at most one.
  assign prod = PROD_W'(in_res.quot) * RECIP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_rdy) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_rdy) begin
      a_quot_r <= in_res.quot;
      a_west_r <= prod[RECIP_SHIFT +: QWH_W];
      a_err_r  <= in_res.err;
    end
  end

  assign back     = QUOT_W'(a_west_r) * QUOT_W'(SCALE);
  assign rem_full = a_quot_r - back;
  assign rem_est  = rem_full[REM_EST_W-1:0];

  always_comb begin
    b_res_nxt.err = a_err_r;
    if (rem_est >= REM_EST_W'(SCALE)) begin
      b_res_nxt.whole = a_west_r + QWH_W'(1);
      b_res_nxt.rem   = REM_W'(rem_est - REM_EST_W'(SCALE));
    end else begin
      b_res_nxt.whole = a_west_r;
      b_res_nxt.rem   = rem_est[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_rdy) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_v_r && b_rdy) begin
      b_res_r <= b_res_nxt;
    end
  end

  assign in_ready  = a_rdy;
  assign out_valid = b_v_r;
  assign out_res   = b_res_r;

endmodule

// ===== src/ufbd_round.sv =====
// Rounds the hundredths to sixteenths, applies the carry and saturates on
// error or whole-part overflow; holds the output register. Depends on ufbd_pkg.
module ufbd_round import ufbd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  split_res_t in_res,
  output logic       out_valid,
  input  logic       out_ready,
  output ufbd_res_t  out_res
);

  logic              v_r;
  ufbd_res_t         res_r;
  ufbd_res_t         res_nxt;
  logic              rdy;
  logic [FRAC_W:0]   frac_rnd;
  logic [QWH_W:0]    whole_sum;

  assign rdy       = !v_r || out_ready;
  assign frac_rnd  = round_frac(in_res.rem);
  assign whole_sum = {1'b0, in_res.whole} + (QWH_W+1)'(frac_rnd[FRAC_W]);

  always_comb begin
    if (in_res.err || whole_sum > (QWH_W+1)'(WHOLE_MAX)) begin
      res_nxt.whole = WHOLE_MAX;
      res_nxt.frac  = FRAC_MAX;
      res_nxt.err   = 1'b1;
    end else begin
      res_nxt.whole = whole_sum[WHOLE_W-1:0];
      res_nxt.frac  = frac_rnd[FRAC_W-1:0];
      res_nxt.err   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy) begin
      res_r <= res_nxt;
    end
  end

  assign in_ready  = rdy;
  assign out_valid = v_r;
  assign out_res   = res_r;

endmodule

// ===== src/uart_fractional_baud_divisor.sv =====
// Top level of the UART fractional baud divisor. Depends on ufbd_pkg,
// ufbd_if, ufbd_divider, ufbd_split and ufbd_round.
//
// For each requested bit rate this block returns the 16x-oversampling
// divisor for a 32 MHz clock: the whole part, the fraction in sixteenths
// (nearest, ties low, carry into the whole part) and an error flag for a
// zero rate or a whole part above 16 bits, in which case the outputs read
// 65535 and 15. It accepts one transaction per cycle unless the pipeline is
// backed up by output back-pressure, and returns results in order. The
// pipelined restoring divider, one stage per BITS_PER_STAGE quotient bits,
// comes first, then two stages split off the hundredths and one stage
// rounds into the output register. Every stage only stalls when its
// successor is full, so bubbles are squeezed out under output back-pressure.
module uart_fractional_baud_divisor import ufbd_pkg::*; #(
  parameter int BITS_PER_STAGE = DIV_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ufbd_in_if.sink   in_bus,
  ufbd_out_if.source out_bus
);

  logic       div_valid;
  logic       div_ready;
  div_res_t   div_res;
  logic       split_valid;
  logic       split_ready;
  split_res_t split_res;
  ufbd_res_t  fin_res;

  ufbd_divider #(
    .BITS_PER_STAGE(BITS_PER_STAGE)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .in_rate  (in_bus.bit_rate),
    .out_valid(div_valid),
    .out_ready(div_ready),
    .out_res  (div_res)
  );

  ufbd_split u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (div_valid),
    .in_ready (div_ready),
    .in_res   (div_res),
    .out_valid(split_valid),
    .out_ready(split_ready),
    .out_res  (split_res)
  );

  ufbd_round u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (split_valid),
    .in_ready (split_ready),
    .in_res   (split_res),
    .out_valid(out_bus.valid),
    .out_ready(out_bus.ready),
    .out_res  (fin_res)
  );

  assign out_bus.divisor_whole    = fin_res.whole;
  assign out_bus.divisor_fraction = fin_res.frac;
  assign out_bus.rate_error       = fin_res.err;

endmodule

// ===== src/ufbd_checker.sv =====
// Port-level checks for the UART fractional baud divisor, bound to the top
// level. Depends on ufbd_pkg and uart_fractional_baud_divisor.
module ufbd_checker import ufbd_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [WHOLE_W-1:0] out_whole,
  input logic [FRAC_W-1:0]  out_frac,
  input logic               out_err
);

  // A held result must not change until its transaction completes.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_whole) &&
                                   $stable(out_frac) && $stable(out_err)))
    else $error("output changed while stalled");

  // Every error result carries the saturated divisor.
  a_err_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_err) |-> (out_whole == WHOLE_MAX && out_frac == FRAC_MAX))
    else $error("error result not saturated");

  // The input side only blocks when the whole pipeline is backed up.
  a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input blocked while output not stalled");

  // Reset empties the output stage.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind uart_fractional_baud_divisor ufbd_checker u_ufbd_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_bus.ready),
  .out_valid(out_bus.valid),
  .out_ready(out_bus.ready),
  .out_whole(out_bus.divisor_whole),
  .out_frac (out_bus.divisor_fraction),
  .out_err  (out_bus.rate_error)
);
